// ===== hw/rtl/cfr_pkg.sv =====
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared types, codes and constants of the checked frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package cfr_pkg;

  // Default depth of the frame store in bytes.
  localparam int BUFFER_BYTES_DEFAULT = 16;

  localparam int BYTE_W      = 8;
  localparam int COUNT_W     = 4;
  localparam int STATUS_W    = 2;
  localparam int CFG_INDEX_W = 8;

  // Configuration register indices.
  localparam logic [CFG_INDEX_W-1:0] REG_START_MARKER = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OWN_ADDRESS  = 8'd1;

  localparam logic [BYTE_W-1:0] START_MARKER_RESET = 8'd95;
  localparam logic [BYTE_W-1:0] OWN_ADDRESS_RESET  = 8'h0D;
  localparam logic [BYTE_W-1:0] BROADCAST_ADDR     = 8'h00;
  localparam logic [BYTE_W-1:0] CSUM_BASE          = 8'hFF;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_BAD_LENGTH = 2'd1,
    ST_CSUM_FAIL  = 2'd2,
    ST_ADDR_FAIL  = 2'd3
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] start_marker;
    logic [BYTE_W-1:0] own_address;
  } cfg_regs_t;

  typedef struct packed {
    status_t            status;
    logic [BYTE_W-1:0]  frame_byte;
    logic [COUNT_W-1:0] byte_offset;
    logic [COUNT_W-1:0] frame_length;
    logic               last;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cfr_if.sv =====
// ----------------------------------------------------------------------------
// cfr_if
// Valid/ready channels of the checked frame receiver: received bytes,
// results and configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfr_rx_if;
  logic                      valid;
  logic                      ready;
  logic [cfr_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfr_res_if;
  logic                        valid;
  logic                        ready;
  logic [cfr_pkg::STATUS_W-1:0] status;
  logic [cfr_pkg::BYTE_W-1:0]   frame_byte;
  logic [cfr_pkg::COUNT_W-1:0]  byte_offset;
  logic [cfr_pkg::COUNT_W-1:0]  frame_length;
  logic                        last;

  modport source (output valid, output status, output frame_byte, output byte_offset,
                  output frame_length, output last, input ready);
  modport sink   (input valid, input status, input frame_byte, input byte_offset,
                  input frame_length, input last, output ready);
endinterface

interface cfr_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [cfr_pkg::CFG_INDEX_W-1:0] index;
  logic [cfr_pkg::BYTE_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cfr_store.sv =====
// ----------------------------------------------------------------------------
// cfr_store
// Frame store: single-port-write, registered-read byte memory.
// ----------------------------------------------------------------------------
`default_nettype none

module cfr_store #(
  parameter int DEPTH = cfr_pkg::BUFFER_BYTES_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [AW-1:0]              wr_addr,
  input  wire logic [cfr_pkg::BYTE_W-1:0] wr_data,
  input  wire logic                       rd_en,
  input  wire logic [AW-1:0]              rd_addr,
  output logic      [cfr_pkg::BYTE_W-1:0] rd_data
);

  logic [cfr_pkg::BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cfr_parser.sv =====
// ----------------------------------------------------------------------------
// cfr_parser
// Frame parser and replay sequencer: tracks the frame phase, writes message
// bytes to the store, checks the frame and reads an accepted frame back out.
// ----------------------------------------------------------------------------
`default_nettype none

module cfr_parser #(
  parameter int BUFFER_BYTES = cfr_pkg::BUFFER_BYTES_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire cfr_pkg::cfg_regs_t         cfg_regs,
  input  wire logic                       in_valid,
  input  wire logic [cfr_pkg::BYTE_W-1:0] rx_byte,
  output logic                            in_ready,
  input  wire logic                       slot_free,
  output logic                            push,
  output cfr_pkg::result_t                res
);

  localparam int AW    = $clog2(BUFFER_BYTES);
  localparam int MAX_M = (BUFFER_BYTES - 1 < 15) ? BUFFER_BYTES - 1 : 15;
  localparam logic [cfr_pkg::BYTE_W-1:0] MAX_L = 8'(MAX_M + 1);

  typedef enum logic [3:0] {
    PH_HUNT    = 4'b0001,
    PH_LENGTH  = 4'b0010,
    PH_MESSAGE = 4'b0100,
    PH_EMIT    = 4'b1000
  } phase_t;

  phase_t                      phase, phase_next;
  logic [cfr_pkg::COUNT_W-1:0] exp_count, exp_count_next;
  logic [cfr_pkg::COUNT_W-1:0] rcvd_count, rcvd_count_next;
  logic [cfr_pkg::COUNT_W-1:0] emit_idx, emit_idx_next;
  logic [cfr_pkg::BYTE_W-1:0]  run_sum, run_sum_next;
  logic [cfr_pkg::BYTE_W-1:0]  addr_byte, addr_byte_next;

  logic                        accept;
  logic                        wr_en;
  logic                        rd_en;
  logic [cfr_pkg::COUNT_W-1:0] rd_idx;
  logic [cfr_pkg::BYTE_W-1:0]  rd_data;
  logic [cfr_pkg::BYTE_W-1:0]  want;
  logic [cfr_pkg::BYTE_W-1:0]  addr_eff;
  logic                        more_body;
  logic                        emit_last;

  cfr_store #(
    .DEPTH (BUFFER_BYTES),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(rcvd_count)),
    .wr_data (rx_byte),
    .rd_en   (rd_en),
    .rd_addr (AW'(rd_idx)),
    .rd_data (rd_data)
  );

  assign in_ready = (phase != PH_EMIT) && slot_free;
  assign accept   = in_valid && in_ready;

  // Checksum target and the address byte; with a two-byte message the
  // address byte is the byte arriving now.
  assign want      = cfr_pkg::CSUM_BASE - run_sum - (8'(exp_count) + 8'd1);
  assign addr_eff  = (rcvd_count == 4'd1) ? rx_byte : addr_byte;
  assign more_body = ({1'b0, rcvd_count} + 5'd1) < {1'b0, exp_count};
  assign emit_last = ({1'b0, emit_idx} + 5'd1) == {1'b0, exp_count};

  always_comb begin
    phase_next      = phase;
    exp_count_next  = exp_count;
    rcvd_count_next = rcvd_count;
    emit_idx_next   = emit_idx;
    run_sum_next    = run_sum;
    addr_byte_next  = addr_byte;
    wr_en           = 1'b0;
    rd_en           = 1'b0;
    rd_idx          = emit_idx;
    push            = 1'b0;
    res             = '0;
    res.status      = cfr_pkg::ST_OK;
    case (phase)
      PH_HUNT: begin
        if (accept) begin
          phase_next = (rx_byte == cfg_regs.start_marker) ? PH_LENGTH : PH_HUNT;
        end
      end
      PH_LENGTH: begin
        if (accept) begin
          if (rx_byte < 8'd2 || rx_byte > MAX_L) begin
            push       = 1'b1;
            res.status = cfr_pkg::ST_BAD_LENGTH;
            res.last   = 1'b1;
            phase_next = PH_HUNT;
          end else begin
            exp_count_next  = 4'(rx_byte - 8'd1);
            rcvd_count_next = '0;
            run_sum_next    = '0;
            phase_next      = PH_MESSAGE;
          end
        end
      end
      PH_MESSAGE: begin
        if (accept) begin
          wr_en           = 1'b1;
          rcvd_count_next = rcvd_count + 4'd1;
          if (rcvd_count == 4'd1) begin
            addr_byte_next = rx_byte;
          end
          if (more_body) begin
            run_sum_next = run_sum + rx_byte;
          end else begin
            phase_next = PH_HUNT;
            if (want != rx_byte) begin
              push             = 1'b1;
              res.status       = cfr_pkg::ST_CSUM_FAIL;
              res.frame_length = exp_count;
              res.last         = 1'b1;
            end else if (exp_count < 4'd2 ||
                         (addr_eff != cfg_regs.own_address &&
                          addr_eff != cfr_pkg::BROADCAST_ADDR)) begin
              push             = 1'b1;
              res.status       = cfr_pkg::ST_ADDR_FAIL;
              res.frame_length = exp_count;
              res.last         = 1'b1;
            end else begin
              // Passing frames have at least two bytes, so entry zero is
              // never the entry written in this cycle.
              phase_next    = PH_EMIT;
              emit_idx_next = '0;
              rd_en         = 1'b1;
              rd_idx        = '0;
            end
          end
        end
      end
      PH_EMIT: begin
        if (slot_free) begin
          push             = 1'b1;
          res.status       = cfr_pkg::ST_OK;
          res.frame_byte   = rd_data;
          res.byte_offset  = emit_idx;
          res.frame_length = exp_count;
          res.last         = emit_last;
          if (emit_last) begin
            phase_next = PH_HUNT;
          end else begin
            emit_idx_next = emit_idx + 4'd1;
            rd_en         = 1'b1;
            rd_idx        = emit_idx + 4'd1;
          end
        end
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      exp_count  <= '0;
      rcvd_count <= '0;
      run_sum    <= '0;
      emit_idx   <= '0;
    end else begin
      phase      <= phase_next;
      exp_count  <= exp_count_next;
      rcvd_count <= rcvd_count_next;
      run_sum    <= run_sum_next;
      emit_idx   <= emit_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    addr_byte <= addr_byte_next;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/checked_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// checked_frame_receiver
// Pulls checked start/length/checksum frames out of a received byte stream.
// ----------------------------------------------------------------------------
// The rx channel takes one received byte per item. The block hunts for the
// start marker, reads a length byte L and then L-1 message bytes, the last of
// which is a checksum. Message bytes are written into an on-chip frame store
// as they arrive while a running sum is kept.
// On the final byte the frame is checked. A rejected frame, or a bad length
// byte, gives a single status item on the result channel in the cycle after
// that byte is accepted. A passing frame is read back from the store one byte
// per cycle while the output register is free or being emptied; each byte
// passes through the registered read port of the store and then the output
// register. While a frame drains, rx is held off; otherwise a byte is
// taken every cycle whenever the output register is free or being emptied.
// The result channel has one output register. When the receiver stalls, the
// item in it holds and nothing moves on until that item is taken. The cfg
// channel is always ready; the user writes it only while the block idles, which the block does not enforce.
// Synchronous reset returns the parser to hunting, empties the output
// register and restores the start marker to 95 and the own address to 13.
// No clearing pass is needed: only bytes of the current frame are read.
// ----------------------------------------------------------------------------
`default_nettype none

module checked_frame_receiver #(
  parameter int BUFFER_BYTES = cfr_pkg::BUFFER_BYTES_DEFAULT
) (
  input wire logic clk,
  input wire logic rst,
  cfr_rx_if.sink   rx,
  cfr_res_if.source result,
  cfr_cfg_if.sink  cfg
);

  cfr_pkg::cfg_regs_t cfg_regs;
  cfr_pkg::result_t   res_next;
  cfr_pkg::result_t   res_q;
  logic               res_valid;
  logic               slot_free;
  logic               push;

  // Configuration registers. Writes to an index outside the list are dropped.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.start_marker <= cfr_pkg::START_MARKER_RESET;
      cfg_regs.own_address  <= cfr_pkg::OWN_ADDRESS_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        cfr_pkg::REG_START_MARKER: cfg_regs.start_marker <= cfg.data;
        cfr_pkg::REG_OWN_ADDRESS:  cfg_regs.own_address  <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // The parser may load the output register when it is empty or when the
  // item in it is being taken in this very cycle.
  assign slot_free = !res_valid || result.ready;

  cfr_parser #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_regs  (cfg_regs),
    .in_valid  (rx.valid),
    .rx_byte   (rx.rx_byte),
    .in_ready  (rx.ready),
    .slot_free (slot_free),
    .push      (push),
    .res       (res_next)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (push) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      res_q <= res_next;
    end
  end

  assign result.valid        = res_valid;
  assign result.status       = res_q.status;
  assign result.frame_byte   = res_q.frame_byte;
  assign result.byte_offset  = res_q.byte_offset;
  assign result.frame_length = res_q.frame_length;
  assign result.last         = res_q.last;

endmodule

`default_nettype wire

// ===== hw/rtl/cfr_checker.sv =====
// ----------------------------------------------------------------------------
// cfr_checker
// Port-level assertions for the checked frame receiver, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module cfr_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         rx_ready,
  input wire logic                         res_valid,
  input wire logic                         res_ready,
  input wire logic [cfr_pkg::STATUS_W-1:0] status,
  input wire logic [cfr_pkg::BYTE_W-1:0]   frame_byte,
  input wire logic [cfr_pkg::COUNT_W-1:0]  byte_offset,
  input wire logic [cfr_pkg::COUNT_W-1:0]  frame_length,
  input wire logic                         last
);

  // A stalled result holds its value.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(status) && $stable(frame_byte)
      && $stable(byte_offset) && $stable(frame_length) && $stable(last))
    else $error("stalled result changed");

  // While an accepted frame is still being replayed, no byte is taken.
  a_no_rx_in_replay: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == cfr_pkg::ST_OK && !last |-> !rx_ready)
    else $error("byte taken during frame replay");

  // A status result stands alone and carries no message byte.
  a_status_alone: assert property (@(posedge clk) disable iff (rst)
    res_valid && status != cfr_pkg::ST_OK |-> last && frame_byte == 8'd0
      && byte_offset == 4'd0)
    else $error("malformed status result");

  // Replayed bytes lie inside the frame, and the last one closes it.
  a_offset_range: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == cfr_pkg::ST_OK |-> byte_offset < frame_length
      && (last == ((byte_offset + 4'd1) == frame_length)))
    else $error("byte offset outside frame");

endmodule

bind checked_frame_receiver cfr_checker u_cfr_checker (
  .clk          (clk),
  .rst          (rst),
  .rx_ready     (rx.ready),
  .res_valid    (result.valid),
  .res_ready    (result.ready),
  .status       (result.status),
  .frame_byte   (result.frame_byte),
  .byte_offset  (result.byte_offset),
  .frame_length (result.frame_length),
  .last         (result.last)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the checked frame receiver. It feeds received bytes
// and register writes, predicts every result item from its own model of the
// parser or from the directed table and scores each result item on the way out, field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import cfr_pkg::*;

  localparam int STORE_BYTES      = BUFFER_BYTES_DEFAULT;
  localparam int MAX_MSG          = (1 << COUNT_W) - 1;
  localparam int BYTE_MAX         = (1 << BYTE_W) - 1;
  localparam int MIN_LENGTH       = 2;
  localparam int ADDR_POS         = 1;
  localparam int CYCLE_LIMIT      = 600000;
  localparam int LONG_HOLD_CYCLES = 250;
  localparam int SETTLE_CYCLES    = 4;
  localparam int TAIL_CYCLES      = 40;
  localparam int PHASE_ITEMS      = 40;
  localparam int SETTING_COUNT    = 4;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_LENGTH,
    PH_MESSAGE
  } rx_phase_t;

  // One row of the directed table: the byte to send and, where the outcome is
  // obvious, the single result item that byte must produce.
  typedef struct packed {
    logic [BYTE_W-1:0] rx;
    logic              typed;
    result_t           outcome;
  } stim_row_t;

  localparam result_t NO_RESULT = '0;
  localparam result_t RES_BAD_LENGTH = '{status: ST_BAD_LENGTH, frame_byte: 8'h00,
                                         byte_offset: 4'd0, frame_length: 4'd0, last: 1'b1};
  localparam result_t RES_ADDR_FAIL_1 = '{status: ST_ADDR_FAIL, frame_byte: 8'h00,
                                          byte_offset: 4'd0, frame_length: 4'd1, last: 1'b1};
  localparam result_t RES_CSUM_FAIL_2 = '{status: ST_CSUM_FAIL, frame_byte: 8'h00,
                                          byte_offset: 4'd0, frame_length: 4'd2, last: 1'b1};
  localparam result_t RES_ADDR_FAIL_3 = '{status: ST_ADDR_FAIL, frame_byte: 8'h00,
                                          byte_offset: 4'd0, frame_length: 4'd3, last: 1'b1};

  // Directed stimulus, all at the reset register values.
  stim_row_t directed_rows [0:23] = '{
    // A stray zero while hunting is simply dropped.
    '{8'h00, 1'b0, NO_RESULT},
    // Length byte of zero, then of one: both too short to hold anything.
    '{START_MARKER_RESET, 1'b0, NO_RESULT}, '{8'h00, 1'b1, RES_BAD_LENGTH},
    '{START_MARKER_RESET, 1'b0, NO_RESULT}, '{8'h01, 1'b1, RES_BAD_LENGTH},
    // Sixteen message bytes exceed the longest message the block takes, fifteen.
    '{START_MARKER_RESET, 1'b0, NO_RESULT}, '{8'h11, 1'b1, RES_BAD_LENGTH},
    // A message of the checksum alone: the checksum is right, but there is no
    // address byte, so the frame fails on its address.
    '{START_MARKER_RESET, 1'b0, NO_RESULT}, '{8'h02, 1'b0, NO_RESULT},
    '{8'hFD, 1'b1, RES_ADDR_FAIL_1},
    // The start marker inside a frame is an ordinary body byte; the checksum
    // that follows is wrong.
    '{START_MARKER_RESET, 1'b0, NO_RESULT}, '{8'h03, 1'b0, NO_RESULT},
    '{START_MARKER_RESET, 1'b0, NO_RESULT}, '{8'h00, 1'b1, RES_CSUM_FAIL_2},
    // Broadcast frame with an all-ones body byte; it passes and is replayed.
    '{START_MARKER_RESET, 1'b0, NO_RESULT}, '{8'h04, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT}, '{BROADCAST_ADDR, 1'b0, NO_RESULT},
    '{8'hFC, 1'b0, NO_RESULT},
    // Good checksum but the frame is for some other station.
    '{START_MARKER_RESET, 1'b0, NO_RESULT}, '{8'h04, 1'b0, NO_RESULT},
    '{8'h12, 1'b0, NO_RESULT}, '{8'h0E, 1'b0, NO_RESULT},
    '{8'hDB, 1'b1, RES_ADDR_FAIL_3}
  };

  logic clk = 1'b0;
  logic rst;

  cfr_rx_if  rx_ch ();
  cfr_res_if res_ch ();
  cfr_cfg_if cfg_ch ();

  checked_frame_receiver u_dut (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Our own copy of the parser state and of the two registers.
  rx_phase_t         rx_phase    = PH_HUNT;
  int unsigned       msg_len     = 0;
  int unsigned       msg_got     = 0;
  logic [BYTE_W-1:0] msg_sum     = '0;
  logic [BYTE_W-1:0] msg_store [STORE_BYTES];
  logic [BYTE_W-1:0] marker_reg  = START_MARKER_RESET;
  logic [BYTE_W-1:0] address_reg = OWN_ADDRESS_RESET;

  // Result items still owed by the block, oldest first, and the items that
  // the byte just decoded gave rise to.
  result_t frame_results_due [$];
  result_t step_results [$];

  // Set by the byte driver alongside each byte: when typed_pending is high the
  // row's written-out outcome stands in for the predicted one.
  logic    typed_pending;
  result_t typed_outcome;

  int unsigned bytes_accepted    = 0;
  int unsigned results_checked   = 0;
  int unsigned frames_passed     = 0;
  int unsigned scoreboard_errors = 0;
  int unsigned settings_used     = 1;
  int unsigned cycle_count       = 0;

  // Idling control shared by both sides of the block.
  logic        quiet_stretch = 1'b0;
  int unsigned holds_asked   = 0;
  int unsigned holds_served  = 0;
  int unsigned hold_left     = 0;
  int unsigned stall_left    = 0;

  // Mostly no gap, often a short one, now and then a long one. During a quiet
  // stretch neither side draws a random gap.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet_stretch || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Advances the parser model by one received byte and leaves whatever result
  // items it gives rise to in step_results.
  function automatic void decode_rx_byte(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] want;
    step_results.delete();
    case (rx_phase)
      PH_LENGTH: begin
        // The length counts itself, so the message is one byte shorter. Too
        // short, too long for the store or for the length field: reject.
        if (b < MIN_LENGTH || int'(b) - 1 >= STORE_BYTES || int'(b) - 1 > MAX_MSG) begin
          rx_phase = PH_HUNT;
          step_results.push_back(RES_BAD_LENGTH);
        end else begin
          msg_len  = int'(b) - 1;
          msg_got  = 0;
          msg_sum  = '0;
          rx_phase = PH_MESSAGE;
        end
      end
      PH_MESSAGE: begin
        msg_store[msg_got] = b;
        msg_got++;
        if (msg_got < msg_len) begin
          msg_sum += b;
        end else begin
          // Final byte is the checksum: all ones less the body sum and length.
          rx_phase = PH_HUNT;
          want = CSUM_BASE - msg_sum - BYTE_W'(msg_len + 1);
          if (want != b) begin
            step_results.push_back('{status: ST_CSUM_FAIL, frame_byte: '0, byte_offset: '0,
                                     frame_length: COUNT_W'(msg_len), last: 1'b1});
          end else if (msg_len < MIN_LENGTH ||
                       (msg_store[ADDR_POS] != address_reg &&
                        msg_store[ADDR_POS] != BROADCAST_ADDR)) begin
            step_results.push_back('{status: ST_ADDR_FAIL, frame_byte: '0, byte_offset: '0,
                                     frame_length: COUNT_W'(msg_len), last: 1'b1});
          end else begin
            for (int k = 0; k < msg_len; k++) begin
              step_results.push_back('{status: ST_OK, frame_byte: msg_store[k],
                                       byte_offset: COUNT_W'(k),
                                       frame_length: COUNT_W'(msg_len),
                                       last: (k + 1 == msg_len)});
            end
          end
        end
      end
      default: begin
        rx_phase = (b == marker_reg) ? PH_LENGTH : PH_HUNT;
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [BYTE_W-1:0] want,
                                      input logic [BYTE_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      scoreboard_errors++;
    end
  endfunction

  // Monitor. Everything is sampled at the rising edge, before the block's own
  // registers move. The result item is scored before the byte taken on the
  // same edge is predicted, since that byte cannot yet have caused it.
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (res_ch.valid && res_ch.ready) begin
        if (frame_results_due.size() == 0) begin
          $display("%0t: result item with none expected: status %0d byte %0h",
                   $time, res_ch.status, res_ch.frame_byte);
          $display("    offset %0d len %0d last %0b",
                   res_ch.byte_offset, res_ch.frame_length, res_ch.last);
          scoreboard_errors++;
        end else begin
          want = frame_results_due.pop_front();
          check_field("status", want.status, res_ch.status);
          check_field("frame_byte", want.frame_byte, res_ch.frame_byte);
          check_field("byte_offset", want.byte_offset, res_ch.byte_offset);
          check_field("frame_length", want.frame_length, res_ch.frame_length);
          check_field("last", want.last, res_ch.last);
          results_checked++;
          if (want.status == ST_OK && want.last) frames_passed++;
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_START_MARKER: marker_reg  = cfg_ch.data;
          REG_OWN_ADDRESS:  address_reg = cfg_ch.data;
          default: ;
        endcase
      end
      if (rx_ch.valid && rx_ch.ready) begin
        bytes_accepted++;
        decode_rx_byte(rx_ch.rx_byte);
        if (typed_pending) begin
          frame_results_due.push_back(typed_outcome);
        end else begin
          foreach (step_results[k]) frame_results_due.push_back(step_results[k]);
        end
      end
    end
  end

  // Watchdog: a hung block ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run stopped after %0d cycles, %0d result items outstanding",
               $time, cycle_count, frame_results_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result receiver. Ready changes on the falling edge. A long hold-off is
  // asked for by the stimulus and counted out here, one cycle per edge.
  always @(negedge clk) begin
    if (holds_served != holds_asked) begin
      holds_served = holds_asked;
      hold_left    = LONG_HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      res_ch.ready = 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      res_ch.ready = 1'b0;
    end else begin
      res_ch.ready = 1'b1;
      stall_left   = pick_gap();
    end
  end

  // Offers one byte, after a random gap, and returns on the edge that takes it.
  // Without a gap valid simply stays high and the data moves on.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic typed,
                           input result_t outcome);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      @(negedge clk);
      rx_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    rx_ch.valid   = 1'b1;
    rx_ch.rx_byte = b;
    typed_pending = typed;
    typed_outcome = outcome;
    do @(posedge clk); while (!rx_ch.ready);
  endtask

  // Stops sending and waits until every owed result item has come out.
  task automatic wait_drained();
    @(negedge clk);
    rx_ch.valid = 1'b0;
    while (frame_results_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // One random frame. Most are well formed with random content, so that the
  // checksum and address stages are reached; some carry a bad length, a
  // foreign address or a corrupt checksum. Line noise may precede the marker
  // and is not counted in the returned number of bytes.
  task automatic send_frame(output int unsigned items);
    int unsigned       msg_bytes;
    int unsigned       pick;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] sum;
    items         = 0;
    quiet_stretch = ($urandom_range(0, 4) == 0);
    repeat (($urandom_range(0, 9) < 3) ? $urandom_range(1, 3) : 0) begin
      b = BYTE_W'($urandom);
      if (b == marker_reg) b = ~b;
      send_byte(b, 1'b0, NO_RESULT);
    end
    send_byte(marker_reg, 1'b0, NO_RESULT);
    items++;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      // Length byte that can never be honoured.
      if (pick < 5) b = BYTE_W'($urandom_range(0, MIN_LENGTH - 1));
      else b = BYTE_W'($urandom_range(STORE_BYTES + 1, BYTE_MAX));
      send_byte(b, 1'b0, NO_RESULT);
      items++;
    end else begin
      // Short frames mostly; the longest ones now and then.
      msg_bytes = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6)
                                             : $urandom_range(7, MAX_MSG);
      send_byte(BYTE_W'(msg_bytes + 1), 1'b0, NO_RESULT);
      items++;
      sum = '0;
      for (int k = 0; k < msg_bytes - 1; k++) begin
        b = BYTE_W'($urandom);
        if (k == ADDR_POS) begin
          pick = $urandom_range(0, 99);
          if (pick < 45) b = address_reg;
          else if (pick < 70) b = BROADCAST_ADDR;
        end
        sum += b;
        send_byte(b, 1'b0, NO_RESULT);
        items++;
      end
      b = CSUM_BASE - sum - BYTE_W'(msg_bytes + 1);
      if ($urandom_range(0, 99) < 15) b = BYTE_W'($urandom);
      send_byte(b, 1'b0, NO_RESULT);
      items++;
    end
  endtask

  initial begin
    int unsigned phase_items;
    int unsigned frame_items;
    rst            = 1'b1;
    rx_ch.valid    = 1'b0;
    rx_ch.rx_byte  = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = REG_START_MARKER;
    cfg_ch.data    = '0;
    typed_pending  = 1'b0;
    typed_outcome  = NO_RESULT;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // Directed part, walked row by row at the reset register values.
    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].outcome);
    end
    wait_drained();

    // Random part, one register setting per phase. Registers are only touched
    // once every owed item is out and the block has had time to settle.
    for (int p = 0; p < SETTING_COUNT; p++) begin
      repeat (SETTLE_CYCLES) @(negedge clk);
      case (p)
        0: begin
          write_reg(REG_START_MARKER, '0);
          write_reg(REG_OWN_ADDRESS, '0);
        end
        1: begin
          write_reg(REG_START_MARKER, BYTE_W'(BYTE_MAX));
          write_reg(REG_OWN_ADDRESS, BYTE_W'(BYTE_MAX));
        end
        2: begin
          write_reg(REG_START_MARKER, BYTE_W'($urandom));
          write_reg(REG_OWN_ADDRESS, BYTE_W'($urandom));
          // A write to an unmapped index must leave both registers alone.
          write_reg(CFG_INDEX_W'($urandom_range(REG_OWN_ADDRESS + 1, (1 << CFG_INDEX_W) - 1)),
                    BYTE_W'($urandom));
        end
        default: begin
          write_reg(REG_START_MARKER, BYTE_W'($urandom));
          write_reg(REG_OWN_ADDRESS, OWN_ADDRESS_RESET);
        end
      endcase
      settings_used++;
      // In this phase the receiver stops taking results for a long while and
      // frames keep coming, so the block backs up and holds off its input.
      if (p == 1) holds_asked++;
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        send_frame(frame_items);
        phase_items += frame_items;
        if ($urandom_range(0, 7) == 0) wait_drained();
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    $display("Run covered %0d received bytes, %0d result items and %0d passed frames",
             bytes_accepted, results_checked, frames_passed);
    $display("under %0d register settings, with a long receiver hold-off.", settings_used);
    if (scoreboard_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
